[rtl/core/cvm_pkg.sv]
// Package for the click voice mixer: widths, opcodes, beat codes, reset values.
// No dependencies.
package cvm_pkg;
  localparam int VOICES_DEF      = 8;
  localparam int STORE_DEPTH_DEF = 65536;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int LEN_W  = 17;
  localparam int FADE_W = 10;
  localparam int MIX_W  = 19;
  localparam logic [FADE_W-1:0] FADE_RESET = 10'd500;

  localparam logic [1:0] OP_SAMPLE = 2'd0;
  localparam logic [1:0] OP_LOAD_A = 2'd1;
  localparam logic [1:0] OP_LOAD_N = 2'd2;
  localparam logic [1:0] OP_NOP    = 2'd3;

  localparam logic [1:0] BEAT_NONE   = 2'd0;
  localparam logic [1:0] BEAT_ACCENT = 2'd1;
  localparam logic [1:0] BEAT_NORMAL = 2'd2;
  localparam logic [1:0] BEAT_NOP    = 2'd3;

  localparam logic [1:0] REG_ACCENT_LEN = 2'd0;
  localparam logic [1:0] REG_NORMAL_LEN = 2'd1;
  localparam logic [1:0] REG_FADE_MAX   = 2'd2;
endpackage

[rtl/core/cvm_ram.sv]
// Generic simple dual-port synchronous RAM (one write port, one read port) with registered read.
// No dependencies.
module cvm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/cvm_div.sv]
// Restoring divider: unsigned magnitude of a scaled sample by the fade total.
// Depends on cvm_pkg.
module cvm_div import cvm_pkg::*; #(
  parameter int NUM_W = 26
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [NUM_W-1:0]  num,
  input  logic [FADE_W-1:0] den,
  output logic              done,
  output logic [NUM_W-1:0]  quo
);
  localparam int CNT_W = $clog2(NUM_W + 1);
  logic [NUM_W-1:0]  q;
  logic [FADE_W:0]   r;
  logic [FADE_W:0]   r_shift;
  logic [CNT_W-1:0]  cnt;
  logic              busy;

  assign r_shift = {r[FADE_W-1:0], q[NUM_W-1]};
  assign quo = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        q    <= num;
        r    <= '0;
        cnt  <= CNT_W'(NUM_W);
      end else if (busy) begin
        // one quotient bit a cycle
        if (r_shift >= {1'b0, den}) begin
          r <= r_shift - {1'b0, den};
          q <= {q[NUM_W-2:0], 1'b1};
        end else begin
          r <= r_shift;
          q <= {q[NUM_W-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

[rtl/core/click_voice_mixer_with_fade_core.sv]
// Click voice mixer with fade: top level, sequencer over voices, state memories.
// Depends on cvm_pkg, cvm_ram, cvm_div.
//
// One request at a time. A load is answered from S_OUT once the output register is
// free, and the core then takes the next request. A sample request walks the
// voices one by one through a voice-state RAM: an idle slot is read and evaluated
// but not written back, a playing voice without fade adds a store read and the mix, and a
// fading voice also sends its gain through the shared serial divider
// (SAMPLE_BITS + 10 steps, 26 by default).
// A finished result sits in an output register; the next request is accepted as
// soon as the sequencer is idle, even while that result is stalled, and the new
// result is held in the sequencer until the output register is free.
module click_voice_mixer_with_fade_core import cvm_pkg::*; #(
  parameter int VOICES      = VOICES_DEF,
  parameter int STORE_DEPTH = STORE_DEPTH_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [1:0]               opcode,
  input  logic [1:0]               beat,
  input  logic [15:0]              load_address,
  input  logic signed [15:0]       load_value,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [MIX_W-1:0]  mix_sample,
  output logic [1:0]               bang,
  output logic                     voice_dropped,
  output logic [3:0]               active_voices,
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [LEN_W-1:0]         cfg_data
);
  localparam int VI_W  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SA_W  = $clog2(STORE_DEPTH);
  localparam int ST_W  = 1 + LEN_W + 2 * FADE_W; // normal, position, total, left
  localparam int PRD_W = SAMPLE_BITS + FADE_W;
  localparam int ACC_W = (SAMPLE_BITS + 5 > MIX_W + 1) ? SAMPLE_BITS + 5 : MIX_W + 1;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EVAL, S_SREAD, S_DIV, S_WB, S_OUT
  } state_t;

  state_t state;
  logic [LEN_W-1:0]  accent_length, normal_length;
  logic [FADE_W-1:0] fade_max;
  logic [VOICES-1:0] busy;
  logic [VI_W-1:0]   vi;
  logic [1:0]        beat_r;
  logic              do_beat, started, dropped_r;
  logic [VI_W-1:0]   slot;
  logic signed [ACC_W-1:0] acc;

  // voice state RAM
  logic            st_we;
  logic [ST_W-1:0] st_wdata, st_rdata;
  logic [VI_W-1:0] st_waddr;
  cvm_ram #(.WIDTH(ST_W), .DEPTH(1 << VI_W)) u_state (
    .clk(clk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(vi), .rdata(st_rdata)
  );

  // sample stores
  logic                   ld_a, ld_n;
  logic [SA_W-1:0]        s_addr, ld_addr;
  logic [SAMPLE_BITS-1:0] ld_val, a_rd, n_rd;
  assign ld_addr = SA_W'(load_address);
  assign ld_val  = SAMPLE_BITS'(load_value);
  cvm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(STORE_DEPTH)) u_accent (
    .clk(clk), .we(ld_a), .waddr(ld_addr), .wdata(ld_val), .raddr(s_addr), .rdata(a_rd)
  );
  cvm_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(STORE_DEPTH)) u_normal (
    .clk(clk), .we(ld_n), .waddr(ld_addr), .wdata(ld_val), .raddr(s_addr), .rdata(n_rd)
  );

  // working copy of current voice
  logic              v_norm;
  logic [LEN_W-1:0]  v_pos, v_len;
  logic [FADE_W-1:0] v_ft, v_fl;
  logic              v_end;
  logic [LEN_W-1:0]  rem;
  logic [FADE_W-1:0] ft_new;

  logic              accept;
  logic [LEN_W-1:0]  beat_len;
  logic [VI_W-1:0]   free_slot;
  logic              any_free;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign ld_a = accept && opcode == OP_LOAD_A;
  assign ld_n = accept && opcode == OP_LOAD_N;
  assign beat_len = (beat == BEAT_ACCENT) ? accent_length : normal_length;

  always_comb begin
    free_slot = '0;
    any_free  = 1'b0;
    for (int i = VOICES - 1; i >= 0; i--) begin
      if (!busy[i]) begin
        free_slot = VI_W'(i);
        any_free  = 1'b1;
      end
    end
  end

  logic              st_norm;
  logic [LEN_W-1:0]  st_pos, st_len;
  logic [FADE_W-1:0] st_ft, st_fl;
  assign {st_norm, st_pos, st_ft, st_fl} = st_rdata;
  assign st_len = st_norm ? normal_length : accent_length;
  assign rem    = (st_len > st_pos) ? st_len - st_pos : '0;
  assign ft_new = (rem < LEN_W'(fade_max)) ? rem[FADE_W-1:0] : fade_max;

  // divider
  logic [SAMPLE_BITS-1:0] samp, samp_mag;
  logic                   samp_neg;
  logic [PRD_W-1:0]       prod_mag, quo;
  logic                   div_start, div_done;
  cvm_div #(.NUM_W(PRD_W)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(prod_mag), .den(v_ft),
    .done(div_done), .quo(quo)
  );

  logic [FADE_W-1:0] fl_dec;
  assign fl_dec = (v_fl != '0) ? v_fl - 1'b1 : '0;

  logic signed [ACC_W-1:0] acc_sat_in;
  assign acc_sat_in = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      accent_length <= '0;
      normal_length <= '0;
      fade_max <= FADE_RESET;
      busy <= '0;
      out_valid <= 1'b0;
      st_we <= 1'b0;
      div_start <= 1'b0;
    end else begin
      st_we <= 1'b0;
      div_start <= 1'b0;
      if (cfg_we) begin
        case (cfg_index)
          REG_ACCENT_LEN: accent_length <= cfg_data;
          REG_NORMAL_LEN: normal_length <= cfg_data;
          REG_FADE_MAX:   fade_max <= cfg_data[FADE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall && state != S_OUT) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            acc <= '0;
            vi <= '0;
            started <= 1'b0;
            dropped_r <= 1'b0;
            beat_r <= BEAT_NONE;
            do_beat <= 1'b0;
            if (opcode == OP_SAMPLE) begin
              do_beat <= (beat == BEAT_ACCENT || beat == BEAT_NORMAL);
              beat_r <= beat;
              if ((beat == BEAT_ACCENT || beat == BEAT_NORMAL) && beat_len != '0) begin
                if (any_free) begin
                  started <= 1'b1;
                  slot <= free_slot;
                end else begin
                  dropped_r <= 1'b1;
                end
              end
              state <= S_RD;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_RD: state <= S_EVAL; // RAM read in flight
        S_EVAL: begin
          v_norm <= st_norm;
          v_pos  <= st_pos;
          v_len  <= st_len;
          v_ft   <= st_ft;
          v_fl   <= st_fl;
          if (started && slot == vi) begin
            // new voice from this beat
            v_norm <= (beat_r == BEAT_NORMAL);
            v_pos  <= '0;
            v_len  <= (beat_r == BEAT_NORMAL) ? normal_length : accent_length;
            v_ft   <= '0;
            v_fl   <= '0;
            busy[vi] <= 1'b1;
            s_addr <= '0;
            state  <= S_SREAD;
          end else if (!busy[vi]) begin
            state <= S_WB;
            v_end <= 1'b1;
          end else begin
            if (do_beat) begin
              v_ft <= ft_new;
              v_fl <= ft_new;
            end
            s_addr <= SA_W'(st_pos);
            if (st_pos >= st_len) begin
              busy[vi] <= 1'b0;
              v_end <= 1'b1;
              state <= S_WB;
            end else begin
              v_end <= 1'b0;
              state <= S_SREAD;
            end
          end
        end
        S_SREAD: begin
          // store data valid next cycle; hold
          state <= S_DIV;
          v_end <= 1'b0;
          v_fl  <= fl_dec;
        end
        S_DIV: begin
          if (v_ft == '0) begin
            acc <= acc + ACC_W'($signed(samp));
            state <= S_WB;
          end else if (!div_start && !div_done && prod_mag != '1 && !v_end) begin
            div_start <= 1'b1;
            v_end <= 1'b1; // marks divide in flight
          end else if (div_done) begin
            acc <= samp_neg ? acc - ACC_W'($signed({1'b0, quo}))
                            : acc + ACC_W'($signed({1'b0, quo}));
            state <= S_WB;
          end
        end
        S_WB: begin
          if (busy[vi] && !(v_end && state == S_WB && v_pos >= v_len)) begin
            st_we <= 1'b1;
            st_waddr <= vi;
            st_wdata <= {v_norm, v_pos + 1'b1, v_ft, v_fl};
            if ((v_pos + 1'b1 >= v_len) || (v_ft != '0 && v_fl == '0))
              busy[vi] <= 1'b0;
          end
          if (vi == VI_W'(VOICES - 1)) begin
            state <= S_OUT;
          end else begin
            vi <= vi + 1'b1;
            state <= S_RD;
          end
        end
        S_OUT: begin
          if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            if (acc > ACC_W'(signed'((1 <<< (MIX_W - 1)) - 1)))
              mix_sample <= MIX_W'((1 <<< (MIX_W - 1)) - 1);
            else if (acc < -ACC_W'(signed'(1 <<< (MIX_W - 1))))
              mix_sample <= MIX_W'(-(1 <<< (MIX_W - 1)));
            else
              mix_sample <= MIX_W'(acc_sat_in);
            bang <= started ? beat_r : BEAT_NONE;
            voice_dropped <= dropped_r;
            active_voices <= 4'($countones(busy));
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign samp = v_norm ? n_rd : a_rd;
  assign samp_neg = samp[SAMPLE_BITS-1];
  assign samp_mag = samp_neg ? ~samp + 1'b1 : samp;
  // magnitude of sample times fade left
  assign prod_mag = PRD_W'(samp_mag) * PRD_W'(v_fl);
endmodule

[rtl/core/cvm_checker.sv]
// Port-level checker for the click voice mixer, bound to the top level.
// Depends on cvm_pkg.
module cvm_checker import cvm_pkg::*; #(
  parameter int VOICES = VOICES_DEF
) (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [1:0] bang,
  input logic       voice_dropped,
  input logic [3:0] active_voices,
  input logic signed [MIX_W-1:0] mix_sample
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(mix_sample))
    else $error("stalled result changed");
  a_bang_drop: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(voice_dropped && bang != BEAT_NONE))
    else $error("bang with drop");
  a_bang_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bang != BEAT_NOP)
    else $error("bad bang");
  a_active_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> {1'b0, active_voices} <= 5'(VOICES))
    else $error("too many voices");
  a_stall_known: assert property (@(posedge clk) disable iff (rst)
    !$isunknown(in_stall))
    else $error("unknown input stall");
endmodule

bind click_voice_mixer_with_fade_core cvm_checker #(.VOICES(VOICES)) u_cvm_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .bang(bang),
  .voice_dropped(voice_dropped), .active_voices(active_voices),
  .mix_sample(mix_sample)
);

[bench/tb.sv]
// Self-checking bench for click_voice_mixer_with_fade_core: drives sample, load and nop
// requests and register writes, predicts every result with a cycle-free model of the mixer.
// Depends on cvm_pkg and the core RTL.
`timescale 1ns / 1ps

typedef struct {
  logic signed [18:0] mix;
  logic [1:0]         bang;
  logic               dropped;
  logic [3:0]         active;
} mix_result_t;

class mix_predictor;
  logic [16:0] accent_len, normal_len;
  logic [9:0]  fade_max;
  bit          busy[8], is_normal[8];
  int unsigned pos[8], fade_len[8], fade_left[8];
  int          accent_mem[int], normal_mem[int];
  mix_result_t expected_mixes[$];
  int          errors;

  function new();
    accent_len = 0;
    normal_len = 0;
    fade_max = cvm_pkg::FADE_RESET;
    errors = 0;
    for (int v = 0; v < 8; v++) begin
      busy[v] = 0; is_normal[v] = 0; pos[v] = 0; fade_len[v] = 0; fade_left[v] = 0;
    end
  endfunction

  function int unsigned len_of(int v);
    return is_normal[v] ? normal_len : accent_len;
  endfunction

  // True when the voice will read a store word on its next sample that was never loaded.
  function bit needs_word(int v);
    if (!busy[v] || pos[v] >= len_of(v)) return 0;
    return is_normal[v] ? !normal_mem.exists(pos[v] % 65536)
                        : !accent_mem.exists(pos[v] % 65536);
  endfunction

  function void set_reg(logic [1:0] idx, logic [16:0] val);
    case (idx)
      cvm_pkg::REG_ACCENT_LEN: accent_len = val;
      cvm_pkg::REG_NORMAL_LEN: normal_len = val;
      cvm_pkg::REG_FADE_MAX:   fade_max = val[9:0];
      default: ;
    endcase
  endfunction

  function void note_request(logic [1:0] op, logic [1:0] bt, logic [15:0] addr,
                             logic signed [15:0] val);
    mix_result_t r;
    longint acc, s;
    int unsigned rem, ft, fl, len, n;
    int slot;
    bit done;
    acc = 0;
    r.bang = cvm_pkg::BEAT_NONE;
    r.dropped = 0;
    if (op == cvm_pkg::OP_LOAD_A) accent_mem[addr] = val;
    else if (op == cvm_pkg::OP_LOAD_N) normal_mem[addr] = val;
    else if (op == cvm_pkg::OP_SAMPLE) begin
      if (bt == cvm_pkg::BEAT_ACCENT || bt == cvm_pkg::BEAT_NORMAL) begin
        // every playing voice goes into a fade first
        for (int v = 0; v < 8; v++) begin
          if (busy[v]) begin
            len = len_of(v);
            rem = len > pos[v] ? len - pos[v] : 0;
            ft = rem < fade_max ? rem : fade_max;
            fade_len[v] = ft;
            fade_left[v] = ft;
          end
        end
        len = (bt == cvm_pkg::BEAT_ACCENT) ? accent_len : normal_len;
        if (len > 0) begin
          slot = -1;
          for (int v = 7; v >= 0; v--) if (!busy[v]) slot = v;
          if (slot < 0) r.dropped = 1;
          else begin
            busy[slot] = 1;
            is_normal[slot] = (bt == cvm_pkg::BEAT_NORMAL);
            pos[slot] = 0;
            fade_len[slot] = 0;
            fade_left[slot] = 0;
            r.bang = bt;
          end
        end
      end
      for (int v = 0; v < 8; v++) begin
        if (busy[v]) begin
          len = len_of(v);
          if (pos[v] >= len) busy[v] = 0;
          else begin
            if (is_normal[v])
              s = normal_mem.exists(pos[v] % 65536) ? normal_mem[pos[v] % 65536] : 0;
            else
              s = accent_mem.exists(pos[v] % 65536) ? accent_mem[pos[v] % 65536] : 0;
            done = 0;
            if (fade_len[v] != 0) begin
              fl = fade_left[v] > 0 ? fade_left[v] - 1 : 0;
              fade_left[v] = fl;
              s = (s * longint'(fl)) / longint'(fade_len[v]);
              if (fl == 0) done = 1;
            end
            acc += s;
            pos[v]++;
            if (pos[v] >= len) done = 1;
            if (done) busy[v] = 0;
          end
        end
      end
      if (acc > 262143) acc = 262143;
      if (acc < -262144) acc = -262144;
    end
    r.mix = acc[18:0];
    n = 0;
    for (int v = 0; v < 8; v++) n += busy[v];
    r.active = n[3:0];
    expected_mixes = {expected_mixes, r};
  endfunction

  function void check_mix(mix_result_t got);
    mix_result_t e;
    if (expected_mixes.size() == 0) begin
      $display("%0t: unexpected result mix=%0d bang=%0d dropped=%0d active=%0d",
               $time, got.mix, got.bang, got.dropped, got.active);
      errors++;
      return;
    end
    e = expected_mixes.pop_front();
    if (got.mix !== e.mix) begin
      $display("%0t: mix_sample expected %0d got %0d", $time, e.mix, got.mix);
      errors++;
    end
    if (got.bang !== e.bang) begin
      $display("%0t: bang expected %0d got %0d", $time, e.bang, got.bang);
      errors++;
    end
    if (got.dropped !== e.dropped) begin
      $display("%0t: voice_dropped expected %0d got %0d", $time, e.dropped, got.dropped);
      errors++;
    end
    if (got.active !== e.active) begin
      $display("%0t: active_voices expected %0d got %0d", $time, e.active, got.active);
      errors++;
    end
  endfunction
endclass

module tb;
  import cvm_pkg::*;

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_stall;
  logic [1:0] opcode = 0, beat = 0;
  logic [15:0] load_address = 0;
  logic signed [15:0] load_value = 0;
  logic out_valid, out_stall = 0;
  logic signed [MIX_W-1:0] mix_sample;
  logic [1:0] bang;
  logic voice_dropped;
  logic [3:0] active_voices;
  logic cfg_we = 0;
  logic [1:0] cfg_index = REG_ACCENT_LEN;
  logic [LEN_W-1:0] cfg_data = 0;

  mix_predictor model = new();
  int phase = 0;
  int quiet_cycles = 0;
  bit held = 0;

  always #2 clk = ~clk;

  click_voice_mixer_with_fade_core u_top (.*);

  always @(posedge clk) begin
    if (out_valid && !out_stall)
      model.check_mix('{mix_sample, bang, voice_dropped, active_voices});
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || rst) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Receiver: stall rate depends on the phase; one long hold-off in the last phase.
  initial begin
    forever begin
      @(negedge clk);
      if (phase == 2 && !held) begin
        held = 1;
        out_stall = 1;
        repeat (400) @(negedge clk);
      end
      out_stall = (phase == 0) ? ($urandom_range(99) < 78)
                : (phase == 1) ? ($urandom_range(99) < 29) : 1'b0;
    end
  end

  task automatic push_request(logic [1:0] op, logic [1:0] bt, logic [15:0] addr,
                              logic signed [15:0] val);
    int gap;
    gap = 0;
    if (phase == 0 && $urandom_range(99) < 29) gap = $urandom_range(1, 6);
    if (phase == 1 && $urandom_range(99) < 78) gap = $urandom_range(1, 6);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1;
    opcode = op;
    beat = bt;
    load_address = addr;
    load_value = val;
    do @(posedge clk); while (in_stall);
    model.note_request(op, bt, addr, val);
  endtask

  // Fill any store word that a playing voice is about to read, then send the sample.
  task automatic play_sample(logic [1:0] bt);
    for (int v = 0; v < 8; v++)
      if (model.needs_word(v))
        push_request(model.is_normal[v] ? OP_LOAD_N : OP_LOAD_A, BEAT_NONE,
                     model.pos[v][15:0], 16'($urandom));
    push_request(OP_SAMPLE, bt, 16'($urandom), 16'($urandom));
  endtask

  task automatic write_reg(logic [1:0] idx, logic [16:0] val);
    @(negedge clk);
    in_valid = 0;
    while (model.expected_mixes.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    model.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic set_all(logic [16:0] a, logic [16:0] n, logic [9:0] f);
    write_reg(REG_ACCENT_LEN, a);
    write_reg(REG_NORMAL_LEN, n);
    write_reg(REG_FADE_MAX, {7'd0, f});
  endtask

  task automatic random_items(int count);
    int k;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      if (k < 12) push_request(OP_LOAD_A, 2'($urandom), 16'($urandom), 16'($urandom));
      else if (k < 20) push_request(OP_LOAD_N, 2'($urandom), 16'($urandom), 16'($urandom));
      else if (k < 24) push_request(OP_NOP, 2'($urandom), 16'($urandom), 16'($urandom));
      else if (k < 50) play_sample(2'($urandom_range(0, 3)));
      else play_sample(BEAT_NONE);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // directed: store extremes, every opcode, both beats, drops, odd codes
    push_request(OP_LOAD_A, BEAT_NONE, 16'd0, 16'sh7fff);
    push_request(OP_LOAD_N, BEAT_NONE, 16'd0, -16'sd32768);
    push_request(OP_LOAD_A, BEAT_NONE, 16'hffff, -16'sd32768);
    push_request(OP_LOAD_N, BEAT_NONE, 16'hffff, 16'sh7fff);
    play_sample(BEAT_ACCENT);
    play_sample(BEAT_NORMAL);
    set_all(17'd65536, 17'd65536, 10'd1023);
    for (int i = 0; i < 9; i++) play_sample(i[0] ? BEAT_NORMAL : BEAT_ACCENT);
    play_sample(BEAT_NOP);
    push_request(OP_NOP, BEAT_NOP, 16'hffff, -16'sd1);
    play_sample(BEAT_NONE);
    set_all(17'd5, 17'd0, 10'd0);
    play_sample(BEAT_NORMAL);
    play_sample(BEAT_ACCENT);
    play_sample(BEAT_NONE);

    for (phase = 0; phase < 3; phase++) begin
      set_all(17'd6, 17'd9, 10'd3);
      random_items(40);
      set_all(17'($urandom_range(1, 40)), 17'($urandom_range(0, 40)),
              10'($urandom_range(0, 20)));
      random_items(40);
      set_all(17'd65536, 17'($urandom_range(1, 65536)), 10'd1);
      random_items(20);
      set_all(17'd2, 17'd3, 10'd1023);
      random_items(20);
    end

    @(negedge clk);
    in_valid = 0;
    while (model.expected_mixes.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (model.errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end
endmodule
